// File: design/ace_pkg.sv
// Shared types, opcodes and constants for the accumulator machine execute block.
package ace_pkg;

  // Data path width and divider sequencing
  localparam int DATA_W    = 32;
  localparam int DIV_STEPS = DATA_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Opcodes, ASCII coded
  localparam logic [7:0] OP_ADD    = 8'h61;  // 'a'
  localparam logic [7:0] OP_SUB    = 8'h73;  // 's'
  localparam logic [7:0] OP_DIV    = 8'h64;  // 'd'
  localparam logic [7:0] OP_TRAP   = 8'h74;  // 't'
  localparam logic [7:0] OP_NOP    = 8'h6e;  // 'n'
  localparam logic [7:0] OP_JUMP   = 8'h6a;  // 'j'
  localparam logic [7:0] OP_ZJUMP  = 8'h7a;  // 'z'
  localparam logic [7:0] OP_WRITE  = 8'h77;  // 'w'
  localparam logic [7:0] OP_READ   = 8'h72;  // 'r'
  localparam logic [7:0] OP_MEMADD = 8'h6d;  // 'm'
  localparam logic [7:0] OP_INC    = 8'h69;  // 'i'
  localparam logic [7:0] OP_HALT   = 8'h68;  // 'h'

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_COMMIT
  } ace_state_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;      // capture the incoming transaction
    logic div_start;  // load divider with operand magnitudes
    logic div_step;   // one restoring divide step
    logic commit;     // update machine state and load output register
  } ace_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_needed;  // live divide with nonzero divisor
    logic out_free;    // output register can take a result this cycle
  } ace_status_t;

  // Two's complement magnitude (most negative value maps to 2**(DATA_W-1))
  function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] v);
    mag = v[DATA_W-1] ? (~v + {{(DATA_W-1){1'b0}}, 1'b1}) : v;
  endfunction

endpackage

// File: design/ace_ctrl.sv
// Controller state machine: sequences capture, divide iterations and commit.
module ace_ctrl
  import ace_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  ace_status_t status,
  output ace_cmd_t    cmd
);

  ace_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // State and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_stall  = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.div_needed) begin
          cmd.div_start = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = ST_DIV;
        end else begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/ace_dpath.sv
// Datapath: machine registers, operand latch, serial divider and output register.
module ace_dpath
  import ace_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  ace_cmd_t           cmd,
  output ace_status_t        status,
  input  logic [7:0]         in_opcode,
  input  logic signed [31:0] in_operand_one,
  input  logic signed [31:0] in_operand_two,
  input  logic signed [31:0] in_mem_read_data,
  input  logic               in_kernel_mode,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_next_pc,
  output logic signed [31:0] out_acc_value,
  output logic signed [31:0] out_general_value,
  output logic               out_mem_write,
  output logic signed [31:0] out_mem_address,
  output logic signed [31:0] out_mem_write_data,
  output logic               out_exception_raised,
  output logic               out_syscall_raised,
  output logic               out_powered_off
);

  // Architectural state
  logic [31:0]       pc_r, pc_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [DATA_W-1:0] gen_r, gen_nxt;
  logic              pwr_r, pwr_nxt;

  // Captured transaction
  logic [7:0]        op_r;
  logic [DATA_W-1:0] a_r, b_r, mem_r;
  logic              kern_r;

  // Divider; the partial remainder stays below the divisor magnitude
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] quo_r, dvs_r;
  logic              neg_r;
  logic [DATA_W:0]   rem_sh, diff;
  logic [DATA_W-1:0] div_q;

  // Result fields before the output register
  logic [31:0]       step;
  logic              wr, exc, sys;
  logic [31:0]       addr, wdata;
  logic              out_valid_r;

  assign status.div_needed = !pwr_r && (op_r == OP_DIV) && (b_r != '0);
  assign status.out_free   = !out_valid_r || !out_stall;
  assign out_valid         = out_valid_r;

  // Capture the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= in_opcode;
      a_r    <= DATA_W'(in_operand_one);
      b_r    <= DATA_W'(in_operand_two);
      mem_r  <= DATA_W'(in_mem_read_data);
      kern_r <= in_kernel_mode;
    end
  end

  // Restoring divide on magnitudes, one quotient bit per step
  assign rem_sh = {rem_r, quo_r[DATA_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};
  assign div_q  = neg_r ? (~quo_r + {{(DATA_W-1){1'b0}}, 1'b1}) : quo_r;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= '0;
      quo_r <= mag(a_r);
      dvs_r <= mag(b_r);
      neg_r <= a_r[DATA_W-1] ^ b_r[DATA_W-1];
    end else if (cmd.div_step) begin
      if (!diff[DATA_W]) begin
        rem_r <= diff[DATA_W-1:0];
        quo_r <= {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[DATA_W-1:0];
        quo_r <= {quo_r[DATA_W-2:0], 1'b0};
      end
    end
  end

  // Instruction effects
  always_comb begin
    pc_nxt  = pc_r;
    acc_nxt = acc_r;
    gen_nxt = gen_r;
    pwr_nxt = pwr_r;
    step    = 32'd1;
    wr      = 1'b0;
    exc     = 1'b0;
    sys     = 1'b0;
    addr    = '0;
    wdata   = '0;
    if (!pwr_r) begin
      case (op_r)
        OP_ADD: acc_nxt = a_r + b_r;
        OP_SUB: acc_nxt = a_r - b_r;
        OP_DIV: begin
          if (b_r == '0) begin
            exc  = 1'b1;
            step = '0;
          end else begin
            acc_nxt = div_q;
          end
        end
        OP_TRAP: begin
          sys     = 1'b1;
          gen_nxt = a_r;
        end
        OP_JUMP: step = 32'(a_r);
        OP_ZJUMP: begin
          if (acc_r == '0) begin
            step = 32'(a_r);
          end
        end
        OP_WRITE: begin
          wr    = 1'b1;
          addr  = 32'(a_r);
          wdata = 32'(acc_r);
        end
        OP_READ: begin
          addr    = 32'(a_r);
          acc_nxt = mem_r;
        end
        OP_MEMADD: begin
          addr    = 32'(b_r);
          acc_nxt = mem_r + a_r;
        end
        OP_INC: acc_nxt = acc_r + a_r;
        OP_HALT: begin
          step = '0;
          if (kern_r) begin
            pwr_nxt = 1'b1;
          end else begin
            exc = 1'b1;
          end
        end
        default: step = 32'd1;
      endcase
      pc_nxt = pc_r + step;
    end
  end

  // Machine state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= '0;
      acc_r       <= '0;
      gen_r       <= '0;
      pwr_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      pc_r        <= pc_nxt;
      acc_r       <= acc_nxt;
      gen_r       <= gen_nxt;
      pwr_r       <= pwr_nxt;
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_next_pc          <= pc_nxt;
      out_acc_value        <= 32'(acc_nxt);
      out_general_value    <= 32'(gen_nxt);
      out_mem_write        <= wr;
      out_mem_address      <= addr;
      out_mem_write_data   <= wdata;
      out_exception_raised <= exc;
      out_syscall_raised   <= sys;
      out_powered_off      <= pwr_nxt;
    end
  end

endmodule

// File: design/accumulator_cpu_execute.sv
// Top level of the accumulator machine execute block.
// Executes one instruction per input transaction and returns one result transaction
// with the updated PC, accumulator and general register plus memory and interrupt lines.
// One instruction is in flight at a time. Most results pass the decode and commit states
// before they reach the output register, and the next transaction is taken once the
// controller is back in idle; a divide with a nonzero divisor loads the divider in decode
// and adds 32 steps of the restoring divider, which retires one quotient bit per cycle.
// The output register lets the next transaction be accepted and executed while a
// result still waits; commit waits only if that register still holds a stalled result.
// After a privileged halt the machine holds its state and every further instruction
// returns that state with powered_off set.
module accumulator_cpu_execute
  import ace_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_opcode,
  input  logic signed [31:0] in_operand_one,
  input  logic signed [31:0] in_operand_two,
  input  logic signed [31:0] in_mem_read_data,
  input  logic               in_kernel_mode,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_next_pc,
  output logic signed [31:0] out_acc_value,
  output logic signed [31:0] out_general_value,
  output logic               out_mem_write,
  output logic signed [31:0] out_mem_address,
  output logic signed [31:0] out_mem_write_data,
  output logic               out_exception_raised,
  output logic               out_syscall_raised,
  output logic               out_powered_off
);

  ace_cmd_t    cmd;
  ace_status_t status;

  // Sequencer
  ace_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Registers, divider and output stage
  ace_dpath u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .in_opcode            (in_opcode),
    .in_operand_one       (in_operand_one),
    .in_operand_two       (in_operand_two),
    .in_mem_read_data     (in_mem_read_data),
    .in_kernel_mode       (in_kernel_mode),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_next_pc          (out_next_pc),
    .out_acc_value        (out_acc_value),
    .out_general_value    (out_general_value),
    .out_mem_write        (out_mem_write),
    .out_mem_address      (out_mem_address),
    .out_mem_write_data   (out_mem_write_data),
    .out_exception_raised (out_exception_raised),
    .out_syscall_raised   (out_syscall_raised),
    .out_powered_off      (out_powered_off)
  );

endmodule

// File: design/ace_checker.sv
// Port-level checks for the execute block, bound to the top level.
module ace_props (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [7:0]         in_opcode,
  input logic signed [31:0] in_operand_one,
  input logic signed [31:0] in_operand_two,
  input logic signed [31:0] in_mem_read_data,
  input logic               in_kernel_mode,
  input logic               out_valid,
  input logic               out_stall,
  input logic [31:0]        out_next_pc,
  input logic signed [31:0] out_acc_value,
  input logic signed [31:0] out_general_value,
  input logic               out_mem_write,
  input logic signed [31:0] out_mem_address,
  input logic signed [31:0] out_mem_write_data,
  input logic               out_exception_raised,
  input logic               out_syscall_raised,
  input logic               out_powered_off
);

  // A stalled result transaction stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result transaction keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_next_pc) && $stable(out_acc_value) &&
      $stable(out_general_value) && $stable(out_powered_off))
    else $error("result payload changed while stalled");

  // One instruction at a time: busy right after an input transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an instruction is in flight");

  // Powered-off results carry no side effects
  a_off_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_powered_off |->
      !out_mem_write && !out_exception_raised && !out_syscall_raised)
    else $error("side effect reported while powered off");

  // At most one of write, exception and syscall per result
  a_one_effect: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_mem_write, out_exception_raised, out_syscall_raised}))
    else $error("conflicting result lines");

endmodule

bind accumulator_cpu_execute ace_props u_ace_props (.*);
